/* design/utf8_stream_validator_macros.svh */
// assertion macros for the utf8 stream validator
// each check is sampled on clk_i and switched off while rst_ni is low
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

`ifndef SYNTHESIS

// condition that must hold at every edge out of reset
`define UTF8V_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define UTF8V_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define UTF8V_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UTF8V_ASSERT_ALWAYS(label, cond, msg)
`define UTF8V_ASSERT_SAME(label, ante, cons, msg)
`define UTF8V_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* design/utf8v_pkg.sv */
`default_nettype none

package utf8v_pkg;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    LIM_ANY = 3'd0,
    LIM_E0  = 3'd1,
    LIM_ED  = 3'd2,
    LIM_F0  = 3'd3,
    LIM_F4  = 3'd4
  } lim_e;

  // byte boundaries
  localparam logic [7:0] CONT_LO      = 8'h80;
  localparam logic [7:0] CONT_HI      = 8'hBF;
  localparam logic [7:0] LEAD2_LO     = 8'hC2;
  localparam logic [7:0] LEAD2_HI     = 8'hDF;
  localparam logic [7:0] LEAD3_LO     = 8'hE0;
  localparam logic [7:0] LEAD3_HI     = 8'hEF;
  localparam logic [7:0] LEAD4_LO     = 8'hF0;
  localparam logic [7:0] LEAD4_HI     = 8'hF4;
  localparam logic [7:0] LEAD_ED      = 8'hED;
  localparam logic [7:0] CONT_E0_LO   = 8'hA0;
  localparam logic [7:0] CONT_ED_HI   = 8'h9F;
  localparam logic [7:0] CONT_F0_LO   = 8'h90;
  localparam logic [7:0] CONT_F4_HI   = 8'h8F;
  localparam logic [7:0] BYTE_NUL     = 8'h00;

  // one input request
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } req_t;

  // decoder state carried between bytes
  typedef struct packed {
    logic [1:0] pend;
    lim_e       lim;
    logic       err;
  } state_t;

  // one result
  typedef struct packed {
    logic error_seen;
    logic message_done;
    logic message_valid;
  } res_t;

endpackage

`default_nettype wire

/* design/utf8v_in_reg.sv */
`default_nettype none

module utf8v_in_reg import utf8v_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  input  wire req_t req_i,
  output logic      req_stall_o,
  output logic      valid_o,
  output req_t      req_o,
  input  wire logic advance_i
);

  logic valid_q;
  logic valid_d;
  req_t req_q;
  logic load;

  // hold while the stored request cannot move on
  assign req_stall_o = valid_q && !advance_i;
  assign load        = req_valid_i && !req_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

/* design/utf8v_decode.sv */
`default_nettype none

module utf8v_decode import utf8v_pkg::*; (
  input  wire req_t   req_i,
  input  wire state_t state_i,
  output state_t      state_o,
  output res_t        res_o
);

  logic [7:0] b;
  logic [7:0] lo;
  logic [7:0] hi;
  logic [1:0] pend;
  lim_e       lim;
  logic       err;

  assign b = req_i.byte_value;

  // continuation byte range for the current limit
  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    unique case (state_i.lim)
      LIM_E0:  lo = CONT_E0_LO;
      LIM_ED:  hi = CONT_ED_HI;
      LIM_F0:  lo = CONT_F0_LO;
      LIM_F4:  hi = CONT_F4_HI;
      default: begin
        lo = CONT_LO;
        hi = CONT_HI;
      end
    endcase
  end

  // byte classification and state step
  always_comb begin
    err  = state_i.err;
    pend = state_i.pend;
    lim  = LIM_ANY;
    if (state_i.pend != 2'd0) begin
      if (b < lo || b > hi) begin
        err = 1'b1;
      end
      pend = state_i.pend - 2'd1;
    end else begin
      priority if (b == BYTE_NUL) begin
        err = 1'b1;
      end else if (b < CONT_LO) begin
        // plain ascii
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        pend = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        pend = 2'd2;
        if (b == LEAD3_LO) begin
          lim = LIM_E0;
        end else if (b == LEAD_ED) begin
          lim = LIM_ED;
        end
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        pend = 2'd3;
        if (b == LEAD4_LO) begin
          lim = LIM_F0;
        end else if (b == LEAD4_HI) begin
          lim = LIM_F4;
        end
      end else begin
        err = 1'b1;
      end
    end
    // sequence cut short by the last byte
    if (req_i.last_byte && pend != 2'd0) begin
      err = 1'b1;
    end
  end

  // clear everything after the last byte
  always_comb begin
    if (req_i.last_byte) begin
      state_o = '{pend: 2'd0, lim: LIM_ANY, err: 1'b0};
    end else begin
      state_o = '{pend: pend, lim: lim, err: err};
    end
  end

  assign res_o = '{error_seen:    err,
                   message_done:  req_i.last_byte,
                   message_valid: req_i.last_byte && !err};

endmodule

`default_nettype wire

/* design/utf8_stream_validator.sv */
// utf8 stream validator
// input channel: one byte per request on byte_value_i, last_byte_i marks the
//   final byte of a message; a request is taken when in_valid_i is high and
//   in_stall_o is low
// output channel: one result per byte on error_seen_o, message_done_o and
//   message_valid_o; a result is taken when out_valid_o is high and
//   out_stall_i is low
// a byte held in the input register is decoded and its result is written to
//   the result register; throughput: one byte per cycle while out_stall_i is
//   low; the input register feeds the decoder, whose state and result
//   register are both written in the same cycle
// error_seen_o is sticky over the message; on the last byte message_valid_o
//   gives the verdict and the decoder state clears for the next message
// reset clears the decoder state and both valid flags; requests in flight
//   are dropped
// when out_stall_i is high the result holds, the input register holds its
//   byte and in_stall_o rises only once that register is full
`default_nettype none

`include "utf8_stream_validator_macros.svh"

module utf8_stream_validator import utf8v_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_value_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            error_seen_o,
  output logic            message_done_o,
  output logic            message_valid_o
);

  req_t   in_req;
  req_t   s1_req;
  logic   s1_valid;
  logic   out_ready;
  logic   advance;
  state_t state_q;
  state_t state_d;
  res_t   res_d;
  res_t   res_q;
  logic   out_valid_q;

  assign in_req = '{byte_value: byte_value_i, last_byte: last_byte_i};

  // input register
  utf8v_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_req),
    .req_stall_o (in_stall_o),
    .valid_o     (s1_valid),
    .req_o       (s1_req),
    .advance_i   (advance)
  );

  // per-byte decode
  utf8v_decode u_decode (
    .req_i   (s1_req),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // output register frees when empty or when its result is taken
  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = s1_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{pend: 2'd0, lim: LIM_ANY, err: 1'b0};
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (out_ready) begin
        out_valid_q <= advance;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign error_seen_o    = res_q.error_seen;
  assign message_done_o  = res_q.message_done;
  assign message_valid_o = res_q.message_valid;

  // checks
  `UTF8V_ASSERT_SAME(a_verdict_consistent, out_valid_q && res_q.message_valid, res_q.message_done && !res_q.error_seen, "verdict valid without done or with error")
  `UTF8V_ASSERT_NEXT(a_clear_after_last, advance && s1_req.last_byte, state_q.pend == 2'd0 && state_q.lim == LIM_ANY && !state_q.err, "state not cleared after last byte")
  `UTF8V_ASSERT_NEXT(a_error_sticky, advance && !s1_req.last_byte && res_d.error_seen, state_q.err, "error flag lost inside a message")
  `UTF8V_ASSERT_ALWAYS(a_limit_needs_pending, state_q.lim == LIM_ANY || state_q.pend == 2'd2 || state_q.pend == 2'd3, "range limit set with too few pending bytes")

endmodule

`default_nettype wire
